[hdl/fso_pkg.sv]
package fso_pkg;

    localparam int unsigned DEF_SINE_TABLE_BITS = 11;
    localparam int unsigned FREQ_W      = 24;
    localparam int unsigned INDEX_W     = 24;
    localparam int unsigned PHASE_W     = 32;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned PERIOD_W    = 28;
    localparam int unsigned TBL_VAL_W   = 17;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(22906492);
    localparam logic                FILTER_RESET = 1'b1;

    typedef enum logic [0:0] {
        CFG_FILTER_ENABLE = 1'b0,
        CFG_SAMPLE_PERIOD = 1'b1
    } cfg_addr_t;

    localparam logic signed [18:0] SAT_MAX = 19'sd32767;
    localparam logic signed [18:0] SAT_MIN = -19'sd32767;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // sine of the first quarter, k of 2^qbits steps, scaled by 32768
    function automatic logic signed [TBL_VAL_W-1:0] quarter_sine(input logic [63:0] k,
                                                                input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x  = (k * HALF_PI_Q30 + ((64'd1 << qbits) >> 1)) >> qbits;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int i = 0; i < 6; i++) begin
            t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
        end
        s = (x * t) >> 30;
        r = (s + (64'd1 << 14)) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return TBL_VAL_W'(r);
    endfunction

endpackage

[hdl/feedback_sine_oscillator.sv]
// Self-feedback phase-modulated sine oscillator. Each accepted item yields one
// Q1.15 sample: sine of (phase + index * last output(s) + offset), read from a
// linearly interpolated table of 2^SINE_TABLE_BITS + 1 entries that is built at
// elaboration; sync loads the phase and reads it directly. Each item passes
// through FB, STEP, RDA, RDB, INTERP and OUT before the next is accepted: a
// single shared multiplier is used three times (feedback, phase step,
// interpolation) and the table port is read twice. A finished sample waits in
// the output register while the next item is taken; OUT holds only if it is still full.
module feedback_sine_oscillator import fso_pkg::*; #(
    parameter int unsigned SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [0:0]                 cfg_addr,
    input  logic [PERIOD_W-1:0]        cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [FREQ_W-1:0]   s_frequency,
    input  logic signed [INDEX_W-1:0]  s_fb_index,
    input  logic [PHASE_W-1:0]         s_phase_offset,
    input  logic                       s_sync_enable,
    input  logic [PHASE_W-1:0]         s_sync_phase,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_sample_out
);

    localparam int unsigned TBL_N     = 1 << SINE_TABLE_BITS;
    localparam int unsigned FRAC_BITS = PHASE_W - SINE_TABLE_BITS;
    localparam int unsigned MUL_A_W   = 25;
    localparam int unsigned MUL_B_W   = 29;
    localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;

    typedef logic signed [TBL_VAL_W-1:0] tbl_t [TBL_N+1];

    function automatic tbl_t build_tbl();
        tbl_t tb;
        int unsigned q;
        q = TBL_N / 4;
        for (int unsigned k = 0; k <= TBL_N; k++) begin
            if (k <= q) begin
                tb[k] = quarter_sine(64'(k), SINE_TABLE_BITS - 2);
            end else if (k <= 2 * q) begin
                tb[k] = quarter_sine(64'(2 * q - k), SINE_TABLE_BITS - 2);
            end else if (k <= 3 * q) begin
                tb[k] = -quarter_sine(64'(k - 2 * q), SINE_TABLE_BITS - 2);
            end else begin
                tb[k] = -quarter_sine(64'(4 * q - k), SINE_TABLE_BITS - 2);
            end
        end
        return tb;
    endfunction

    localparam tbl_t SINE_TBL = build_tbl();

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FB     = 7'b0000010,
        S_STEP   = 7'b0000100,
        S_RDA    = 7'b0001000,
        S_RDB    = 7'b0010000,
        S_INTERP = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic                       filter_reg;
    logic [PERIOD_W-1:0]        period_reg;
    logic [PHASE_W-1:0]         run_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [SAMPLE_W-1:0] older_reg;

    logic signed [FREQ_W-1:0]   freq_reg;
    logic signed [INDEX_W-1:0]  index_reg;
    logic [PHASE_W-1:0]         offset_reg;
    logic                       sync_reg;
    logic [PHASE_W-1:0]         sync_ph_reg;
    logic [PHASE_W-1:0]         phase_reg;

    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [TBL_VAL_W-1:0] rom_q_reg;
    logic signed [TBL_VAL_W-1:0] a_reg;

    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;

    logic signed [TBL_VAL_W-1:0] fb_op;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    mul_p;
    logic [SINE_TABLE_BITS:0]    rom_addr;
    logic signed [TBL_VAL_W:0]   diff;
    logic signed [PROD_W-1:0]    round_sum;
    logic signed [PROD_W-1:0]    delta;
    logic signed [18:0]          y_full;
    logic signed [SAMPLE_W-1:0]  y_sat;
    logic signed [PROD_W-1:0]    step_sum;
    logic                        out_free;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign out_free     = !m_valid_reg || m_ready;

    // feedback operand: sum of the last two outputs, or twice the last one
    assign fb_op = filter_reg ? (TBL_VAL_W'(prev_reg) + TBL_VAL_W'(older_reg))
                              : {prev_reg, 1'b0};

    assign diff = (TBL_VAL_W+1)'(rom_q_reg) - (TBL_VAL_W+1)'(a_reg);

    // shared multiplier
    always_comb begin
        case (state_reg)
            S_FB: begin
                mul_a = MUL_A_W'(fb_op);
                mul_b = MUL_B_W'(index_reg);
            end
            S_STEP: begin
                mul_a = MUL_A_W'(freq_reg);
                mul_b = $signed({1'b0, period_reg});
            end
            S_INTERP: begin
                mul_a = MUL_A_W'(diff);
                mul_b = $signed(MUL_B_W'(phase_reg[FRAC_BITS-1:0]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign rom_addr = {1'b0, phase_reg[PHASE_W-1 -: SINE_TABLE_BITS]}
                    + (SINE_TABLE_BITS+1)'(state_reg == S_RDB);

    assign step_sum  = prod_reg + PROD_W'(32768);
    assign round_sum = prod_reg + (PROD_W'(1) <<< (FRAC_BITS - 1));
    assign delta     = round_sum >>> FRAC_BITS;
    assign y_full    = 19'(a_reg) + delta[18:0];

    always_comb begin
        if (y_full > SAT_MAX) begin
            y_sat = SAMPLE_W'(SAT_MAX);
        end else if (y_full < SAT_MIN) begin
            y_sat = SAMPLE_W'(SAT_MIN);
        end else begin
            y_sat = y_full[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_FB;
            S_FB:     state_next = S_STEP;
            S_STEP:   state_next = S_RDA;
            S_RDA:    state_next = S_RDB;
            S_RDB:    state_next = S_INTERP;
            S_INTERP: state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // table read port, registered
    always_ff @(posedge aclk) begin
        rom_q_reg <= SINE_TBL[rom_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            filter_reg  <= FILTER_RESET;
            period_reg  <= PERIOD_RESET;
            run_reg     <= '0;
            prev_reg    <= '0;
            older_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_addr_t'(cfg_addr))
                    CFG_FILTER_ENABLE: filter_reg <= cfg_wdata[0];
                    CFG_SAMPLE_PERIOD: period_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_STEP: begin
                    if (sync_reg) begin
                        run_reg <= sync_ph_reg;
                    end
                end
                S_RDA: begin
                    run_reg <= run_reg + step_sum[47:16];
                end
                S_OUT: begin
                    if (out_free) begin
                        older_reg   <= prev_reg;
                        prev_reg    <= y_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    // item payload and datapath registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            freq_reg    <= s_frequency;
            index_reg   <= s_fb_index;
            offset_reg  <= s_phase_offset;
            sync_reg    <= s_sync_enable;
            sync_ph_reg <= s_sync_phase;
        end
        if (state_reg == S_FB || state_reg == S_STEP || state_reg == S_INTERP) begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_STEP) begin
            phase_reg <= sync_reg ? sync_ph_reg
                                  : run_reg + prod_reg[PHASE_W-1:0] + offset_reg;
        end
        if (state_reg == S_RDB) begin
            a_reg <= rom_q_reg;
        end
        if (state_reg == S_OUT && out_free) begin
            m_sample_reg <= y_sat;
        end
    end

endmodule
